[hw/rtl/cc20_pkg.sv]
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, constants and helpers for the ChaCha20 stream cipher unit.
// ----------------------------------------------------------------------------
package cc20_pkg;

  // "expand 32-byte k" constants
  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  // 10 double rounds, 2 half rounds each, 4 quarter-round steps each
  localparam int ROUND_STEPS = 80;
  localparam int RND_W       = 7;

  localparam int FIFO_DEPTH  = 2;
  localparam int CFG_IDX_W   = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY0  = 3'd0,
    CFG_KEY1  = 3'd1,
    CFG_KEY2  = 3'd2,
    CFG_KEY3  = 3'd3,
    CFG_NONCE_LO = 3'd4,
    CFG_NONCE_HI = 3'd5,
    CFG_START = 3'd6
  } cfg_idx_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } cc_state_t;

  typedef logic [15:0][31:0] word16_t;

  // Configuration as seen by the back end
  typedef struct packed {
    logic [255:0] key;
    logic [95:0]  nonce;
    logic [31:0]  start_ctr;
  } cfg_t;

  // Queued item: byte, end-of-message mark, start-of-message mark
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       first;
  } item_t;

  // Initial 4x4 state for one block
  function automatic word16_t init_state(cfg_t cfg, logic [31:0] ctr);
    word16_t s;
    s[0] = SIGMA0;
    s[1] = SIGMA1;
    s[2] = SIGMA2;
    s[3] = SIGMA3;
    for (int k = 0; k < 8; k++) s[4+k] = cfg.key[32*k +: 32];
    s[12] = ctr;
    s[13] = cfg.nonce[31:0];
    s[14] = cfg.nonce[63:32];
    s[15] = cfg.nonce[95:64];
    return s;
  endfunction

endpackage

[hw/rtl/cc20_front.sv]
// ----------------------------------------------------------------------------
// cc20_front
// Input side: accepts byte transactions, tags the first byte of each message
// and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module cc20_front #(
  parameter int FifoDepth = cc20_pkg::FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  input  logic              in_last_byte,
  output logic              item_valid,
  output cc20_pkg::item_t   item,
  input  logic              pop
);

  localparam int PTR_W = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int CNT_W = $clog2(FifoDepth + 1);

  cc20_pkg::item_t  q_r [FifoDepth];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             first_r;
  logic             push;

  assign in_stall   = (cnt_r == CNT_W'(FifoDepth));
  assign push       = in_valid && !in_stall;
  assign item_valid = (cnt_r != '0);
  assign item       = q_r[rd_ptr_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{data: in_data_byte, last: in_last_byte, first: first_r};
    end
  end

  // Pointers, fill count, message-start tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      first_r  <= 1'b1;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(FifoDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
        first_r  <= in_last_byte;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(FifoDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

[hw/rtl/cc20_back.sv]
// ----------------------------------------------------------------------------
// cc20_back
// Keystream engine: four quarter-round lanes, one add/xor/rotate step per
// cycle, block add-back, and the XOR output register.
// ----------------------------------------------------------------------------
module cc20_back (
  input  logic            clk,
  input  logic            rst_n,
  input  cc20_pkg::cfg_t  cfg,
  input  logic            item_valid,
  input  cc20_pkg::item_t item,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  localparam int RW = cc20_pkg::RND_W;

  cc20_pkg::cc_state_t state_r, state_nxt;
  cc20_pkg::word16_t   w_r, w_nxt, ks_r, ks_nxt, init_w;
  logic [RW-1:0]       rnd_r, rnd_nxt;
  logic [5:0]          pos_r, pos_nxt;
  logic [31:0]         ctr_r, ctr_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_byte_r, out_byte_nxt;
  logic                out_last_r, out_last_nxt;
  logic [31:0]         ks_word;

  assign init_w  = cc20_pkg::init_state(cfg, ctr_r);
  assign ks_word = ks_r[pos_r[5:2]];

  // Sequencer and datapath next state
  always_comb begin
    logic [3:0]  ix, iy, iz;
    logic [1:0]  lb, lc, ld;
    logic [31:0] sum, t, rot;
    state_nxt     = state_r;
    w_nxt         = w_r;
    ks_nxt        = ks_r;
    rnd_nxt       = rnd_r;
    pos_nxt       = pos_r;
    ctr_nxt       = ctr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;
    case (state_r)
      cc20_pkg::ST_IDLE: begin
        if (item_valid) begin
          if (item.first) begin
            ctr_nxt = cfg.start_ctr;
            pos_nxt = '0;
            w_nxt   = cc20_pkg::init_state(cfg, cfg.start_ctr);
          end else begin
            w_nxt   = init_w;
          end
          rnd_nxt   = '0;
          state_nxt = (item.first || pos_r == '0) ? cc20_pkg::ST_ROUND : cc20_pkg::ST_EMIT;
        end
      end
      cc20_pkg::ST_ROUND: begin
        // one step of four quarter rounds (column or diagonal)
        for (int i = 0; i < 4; i++) begin
          lb = 2'(i + (rnd_r[2] ? 1 : 0));
          lc = 2'(i + (rnd_r[2] ? 2 : 0));
          ld = 2'(i + (rnd_r[2] ? 3 : 0));
          if (!rnd_r[0]) begin
            ix = 4'(i);       iy = {2'b01, lb}; iz = {2'b11, ld};
          end else begin
            ix = {2'b10, lc}; iy = {2'b11, ld}; iz = {2'b01, lb};
          end
          sum = w_r[ix] + w_r[iy];
          t   = w_r[iz] ^ sum;
          case (rnd_r[1:0])
            2'd0:    rot = {t[15:0], t[31:16]};
            2'd1:    rot = {t[19:0], t[31:20]};
            2'd2:    rot = {t[23:0], t[31:24]};
            default: rot = {t[24:0], t[31:25]};
          endcase
          w_nxt[ix] = sum;
          w_nxt[iz] = rot;
        end
        rnd_nxt = rnd_r + 1'b1;
        if (rnd_r == RW'(cc20_pkg::ROUND_STEPS - 1)) state_nxt = cc20_pkg::ST_ADD;
      end
      cc20_pkg::ST_ADD: begin
        for (int k = 0; k < 16; k++) ks_nxt[k] = w_r[k] + init_w[k];
        state_nxt = cc20_pkg::ST_EMIT;
      end
      cc20_pkg::ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = item.data ^ ks_word[{pos_r[1:0], 3'b000} +: 8];
          out_last_nxt  = item.last;
          pop           = 1'b1;
          pos_nxt       = pos_r + 1'b1;
          if (pos_r == 6'd63) ctr_nxt = ctr_r + 1'b1;
          if (item.last) pos_nxt = '0;
          state_nxt     = cc20_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cc20_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cc20_pkg::ST_IDLE;
      rnd_r       <= '0;
      pos_r       <= '0;
      ctr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      pos_r       <= pos_nxt;
      ctr_r       <= ctr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    w_r        <= w_nxt;
    ks_r       <= ks_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

`ifndef ASSERT_OFF
  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cc20_pkg::ST_ROUND |-> rnd_r < RW'(cc20_pkg::ROUND_STEPS))
    else $error("round counter out of range");
  a_pop_emit: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> state_r == cc20_pkg::ST_EMIT && item_valid)
    else $error("queue popped outside emit or while empty");
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == cc20_pkg::ST_EMIT)
    else $error("result appeared without an emit step");
  a_add_after_round: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cc20_pkg::ST_ADD |-> $past(state_r) == cc20_pkg::ST_ROUND)
    else $error("add-back without finished rounds");
`endif

endmodule

[hw/rtl/chacha20_stream_cipher_unit.sv]
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_unit
// ChaCha20 byte stream cipher with configuration registers.
// ----------------------------------------------------------------------------
// The back end handles one byte at a time, through its idle and emit states;
// the first byte of every 64-byte block (and of every message) also waits
// for keystream generation in the four shared quarter-round lanes and the
// add-back step. A two-entry input queue and an output register let both
// channels stall independently. Configuration writes (index 0..6, others
// ignored) are always ready and should be made while no transaction is in
// flight.
module chacha20_stream_cipher_unit #(
  parameter int FifoDepth = cc20_pkg::FIFO_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_last_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cc20_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data
);

  logic [63:0]     key0_r, key1_r, key2_r, key3_r, nonce_lo_r;
  logic [31:0]     nonce_hi_r, start_r;
  cc20_pkg::cfg_t  cfg;
  cc20_pkg::item_t item;
  logic            item_valid, pop;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r     <= '0;
      key1_r     <= '0;
      key2_r     <= '0;
      key3_r     <= '0;
      nonce_lo_r <= '0;
      nonce_hi_r <= '0;
      start_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cc20_pkg::CFG_KEY0:     key0_r     <= cfg_data;
        cc20_pkg::CFG_KEY1:     key1_r     <= cfg_data;
        cc20_pkg::CFG_KEY2:     key2_r     <= cfg_data;
        cc20_pkg::CFG_KEY3:     key3_r     <= cfg_data;
        cc20_pkg::CFG_NONCE_LO: nonce_lo_r <= cfg_data;
        cc20_pkg::CFG_NONCE_HI: nonce_hi_r <= cfg_data[31:0];
        cc20_pkg::CFG_START:    start_r    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign cfg.key       = {key3_r, key2_r, key1_r, key0_r};
  assign cfg.nonce     = {nonce_hi_r, nonce_lo_r};
  assign cfg.start_ctr = start_r;

  cc20_front #(.FifoDepth(FifoDepth)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .item_valid   (item_valid),
    .item         (item),
    .pop          (pop)
  );

  cc20_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

endmodule

[verif/chacha20_stream_cipher_unit_tb.sv]
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_unit_tb
// Byte-stream check of the ChaCha20 unit: a local keystream generator
// predicts every output byte, with random valid/stall gaps, several key,
// nonce and counter settings, counter wrap and message boundaries.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_unit_tb;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_xact_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic [7:0]                     in_data_byte;
  logic                           in_last_byte;
  logic                           out_valid;
  logic                           out_stall;
  logic [7:0]                     out_byte;
  logic                           out_last;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [cc20_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [63:0]                    cfg_data;

  chacha20_stream_cipher_unit u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Predictor copy of configuration and cipher state
  logic [63:0]  key_q [4];
  logic [63:0]  nonce_lo_q;
  logic [31:0]  nonce_hi_q;
  logic [31:0]  start_ctr_q;
  logic [31:0]  ks_words [16];
  logic [5:0]   ks_pos;
  logic [31:0]  blk_ctr;
  logic         msg_open;

  byte_xact_t   pending_bytes [$];
  byte_xact_t   expected_bytes [$];
  int           errors;
  int           n_sent;
  int           n_checked;
  int           n_msgs;
  int           idle_cycles;
  int           rx_hold;
  bit           no_idle;
  bit           tx_pause;

  function automatic logic [31:0] rotl(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void qr(ref logic [31:0] w[16], input int a, b, c, d);
    w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 16);
    w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 12);
    w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 8);
    w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 7);
  endfunction

  // Build one keystream block from the current settings
  function automatic void make_keystream();
    logic [31:0] seed [16];
    logic [31:0] w [16];
    seed[0] = 32'h61707865; seed[1] = 32'h3320646e;
    seed[2] = 32'h79622d32; seed[3] = 32'h6b206574;
    for (int k = 0; k < 4; k++) begin
      seed[4+2*k] = key_q[k][31:0];
      seed[5+2*k] = key_q[k][63:32];
    end
    seed[12] = blk_ctr;
    seed[13] = nonce_lo_q[31:0];
    seed[14] = nonce_lo_q[63:32];
    seed[15] = nonce_hi_q;
    w = seed;
    for (int r = 0; r < 10; r++) begin
      qr(w, 0, 4, 8, 12); qr(w, 1, 5, 9, 13);
      qr(w, 2, 6, 10, 14); qr(w, 3, 7, 11, 15);
      qr(w, 0, 5, 10, 15); qr(w, 1, 6, 11, 12);
      qr(w, 2, 7, 8, 13); qr(w, 3, 4, 9, 14);
    end
    for (int k = 0; k < 16; k++) ks_words[k] = w[k] + seed[k];
  endfunction

  // Expected output for one accepted input byte
  function automatic byte_xact_t cipher_byte(byte_xact_t b);
    byte_xact_t r;
    logic [31:0] wd;
    if (!msg_open) begin
      blk_ctr  = start_ctr_q;
      ks_pos   = 6'd0;
      msg_open = 1;
    end
    if (ks_pos == 6'd0) make_keystream();
    wd = ks_words[ks_pos[5:2]];
    r.data = b.data ^ wd[8*ks_pos[1:0] +: 8];
    r.last = b.last;
    ks_pos = ks_pos + 6'd1;
    if (ks_pos == 6'd0) blk_ctr = blk_ctr + 32'd1;
    if (b.last) begin
      msg_open = 0;
      ks_pos   = 6'd0;
    end
    return r;
  endfunction

  // Clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Driver: source transactions from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (pending_bytes.size() > 0 && !tx_pause &&
          (no_idle || $urandom_range(99) >= 36)) begin
        in_valid     <= 1;
        in_data_byte <= pending_bytes[0].data;
        in_last_byte <= pending_bytes[0].last;
        void'(pending_bytes.pop_front());
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Predict at input acceptance
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_bytes.push_back(cipher_byte('{in_data_byte, in_last_byte}));
      n_sent++;
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else if (rx_hold > 0) begin
      rx_hold   <= rx_hold - 1;
      out_stall <= 1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < 36);
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    byte_xact_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected result: out_byte %h out_last %b", out_byte, out_last);
        errors++;
      end else begin
        e = expected_bytes.pop_front();
        if (out_byte !== e.data) begin
          $error("out_byte: expected %h actual %h", e.data, out_byte);
          errors++;
        end
        if (out_last !== e.last) begin
          $error("out_last: expected %b actual %b", e.last, out_last);
          errors++;
        end
        n_checked++;
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || cfg_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(cc20_pkg::cfg_idx_t idx, logic [63:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      cc20_pkg::CFG_KEY0:     key_q[0] = v;
      cc20_pkg::CFG_KEY1:     key_q[1] = v;
      cc20_pkg::CFG_KEY2:     key_q[2] = v;
      cc20_pkg::CFG_KEY3:     key_q[3] = v;
      cc20_pkg::CFG_NONCE_LO: nonce_lo_q = v;
      cc20_pkg::CFG_NONCE_HI: nonce_hi_q = v[31:0];
      cc20_pkg::CFG_START:    start_ctr_q = v[31:0];
      default: ;
    endcase
  endtask

  // Wait for drain plus the block's keystream latency
  task automatic drain();
    while (pending_bytes.size() > 0 || in_valid || expected_bytes.size() > 0)
      @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic load_settings(logic [63:0] kv, logic [63:0] nv, logic [31:0] sc,
                               bit rnd);
    for (int k = 0; k < 4; k++)
      write_reg(cc20_pkg::cfg_idx_t'(k), rnd ? {$urandom, $urandom} : kv);
    write_reg(cc20_pkg::CFG_NONCE_LO, rnd ? {$urandom, $urandom} : nv);
    write_reg(cc20_pkg::CFG_NONCE_HI, rnd ? {32'h0, $urandom} : nv);
    write_reg(cc20_pkg::CFG_START, sc);
    cfg_valid <= 0;
  endtask

  // Queue one message of random bytes
  task automatic queue_msg(int len);
    for (int i = 0; i < len; i++)
      pending_bytes.push_back('{8'($urandom), i == len - 1});
    n_msgs++;
  endtask

  initial begin
    rst_n     = 0;
    cfg_valid = 0;
    cfg_index = cc20_pkg::CFG_KEY0;
    cfg_data  = 0;
    in_valid  = 0;
    in_data_byte = 0;
    in_last_byte = 0;
    out_stall = 0;
    errors    = 0;
    n_sent    = 0;
    n_checked = 0;
    n_msgs    = 0;
    no_idle   = 0;
    tx_pause  = 0;
    rx_hold   = 0;
    idle_cycles = 0;
    for (int k = 0; k < 4; k++) key_q[k] = 0;
    nonce_lo_q  = 0;
    nonce_hi_q  = 0;
    start_ctr_q = 0;
    ks_pos   = 0;
    blk_ctr  = 0;
    msg_open = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: reset settings, extreme data bytes, one-byte message
    pending_bytes.push_back('{8'h00, 1'b0});
    pending_bytes.push_back('{8'hff, 1'b0});
    pending_bytes.push_back('{8'h5a, 1'b1});
    pending_bytes.push_back('{8'ha5, 1'b1});
    drain();

    // All-ones settings; block counter starts at its maximum
    load_settings('1, '1, 32'hffff_ffff, 0);
    queue_msg(20);
    drain();

    // Counter wrap across a block boundary at full rate
    no_idle = 1;
    queue_msg(130);
    drain();
    no_idle = 0;

    // Random settings, random-length messages
    for (int ph = 0; ph < 4; ph++) begin
      load_settings(0, 0, (ph == 0) ? 32'h0 : $urandom, 1);
      for (int m = 0; m < 6; m++) queue_msg($urandom_range(1, 40));
      if (ph == 1) begin
        // long receiver hold while the sender keeps offering
        rx_hold = 200;
      end
      if (ph == 2) begin
        // sender pauses until everything is back
        while (pending_bytes.size() > 40) @(posedge clk);
        tx_pause = 1;
        while (in_valid || expected_bytes.size() > 0) @(posedge clk);
        tx_pause = 0;
      end
      drain();
    end

    $display("Covered %0d bytes in %0d messages, %0d results checked.",
             n_sent, n_msgs, n_checked);
    $display("Settings included all-zero, all-one and random key/nonce/counter.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/cc20_pkg.sv
hw/rtl/cc20_front.sv
hw/rtl/cc20_back.sv
hw/rtl/chacha20_stream_cipher_unit.sv
verif/chacha20_stream_cipher_unit_tb.sv
